[rtl/core/bcg_pkg.sv]
// ----------------------------------------------------------------------------
// bcg_pkg: shared constants and types for the battery charge gauge
// Widths of the sample window, IIR accumulator and output fields, plus the
// reciprocal constants used for the millivolt and percent conversions.
// ----------------------------------------------------------------------------
package bcg_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int WINDOW      = 4;
    localparam int IIR_SHIFT   = 6;

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int ACC_W  = SUM_W + IIR_SHIFT + 1;
    localparam int FILT_W = SUM_W;
    localparam int MV_W   = 15;
    localparam int PCT_W  = 7;

    // Millivolt scaling: mv = floor(filt * MV_NUM / MV_DEN)
    localparam int MV_NUM = 1278;
    localparam int MV_DEN = 1000;

    // Reciprocal multiply: ceil(MV_NUM * 2^MV_SHIFT / MV_DEN); the rounding
    // error times the largest filtered value stays below 2^MV_SHIFT, so the
    // truncated product matches the exact quotient.
    localparam int     MV_SHIFT   = 24;
    localparam int     MV_MULT_W  = 25;
    localparam longint MV_MULT_L  =
        (longint'(MV_NUM) * (longint'(1) << MV_SHIFT) + longint'(MV_DEN) - 1) /
        longint'(MV_DEN);
    localparam logic [MV_MULT_W-1:0] MV_MULT = MV_MULT_W'(MV_MULT_L);

    // Charge curve breakpoints
    localparam int MV_FULL   = 4000;
    localparam int MV_MID    = 3500;
    localparam int MV_EMPTY  = 3000;
    localparam int PCT_MID   = 17;
    localparam int PCT_FULL  = 100;
    localparam int SLOPE_MID = 6;
    localparam int SLOPE_LOW = 29;

    // Segment offsets stay below 512, so 9 bits suffice and the reciprocals
    // below are exact over that range.
    localparam int SEG_W        = 9;
    localparam int DIV6_SHIFT   = 10;
    localparam int DIV6_MULT_W  = 8;
    localparam logic [DIV6_MULT_W-1:0] DIV6_MULT =
        DIV6_MULT_W'(((1 << DIV6_SHIFT) + SLOPE_MID - 1) / SLOPE_MID);
    localparam int DIV29_SHIFT  = 14;
    localparam int DIV29_MULT_W = 10;
    localparam logic [DIV29_MULT_W-1:0] DIV29_MULT =
        DIV29_MULT_W'(((1 << DIV29_SHIFT) + SLOPE_LOW - 1) / SLOPE_LOW);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_W-1:0]       sum_t;

    // Control traveling alongside a transaction between stages
    typedef struct packed {
        logic valid;
        logic first;
    } bcg_ctl_t;

endpackage

[rtl/core/bcg_sample_cell.sv]
// ----------------------------------------------------------------------------
// bcg_sample_cell: one entry of the sample window
// Holds one sample and passes it to the next cell on each accepted
// transaction; on the first transaction after reset it loads the new sample.
// ----------------------------------------------------------------------------
module bcg_sample_cell
    import bcg_pkg::*;
(
    input  logic    aclk,
    input  logic    shift_en,
    input  logic    fill,
    input  sample_t fill_value,
    input  sample_t shift_in,
    output sample_t sample_q
);

    sample_t sample_reg;
    sample_t sample_next;

    always_comb begin
        sample_next = fill ? fill_value : shift_in;
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sample_reg <= sample_next;
        end
    end

    assign sample_q = sample_reg;

endmodule

[rtl/core/bcg_window.sv]
// ----------------------------------------------------------------------------
// bcg_window: sample window and running sum
// A chain of sample cells shifts in each new sample; the running sum drops
// the sample leaving the last cell and adds the incoming one.
// ----------------------------------------------------------------------------
module bcg_window
    import bcg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     take,
    input  sample_t  sample,
    output bcg_ctl_t ctl_q,
    output sum_t     sum_q
);

    sample_t  cell_q [WINDOW];
    logic     primed_reg;
    logic     primed_next;
    sum_t     sum_reg;
    sum_t     sum_next;
    bcg_ctl_t ctl_reg;
    bcg_ctl_t ctl_next;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        sample_t shift_in;
        if (i == 0) begin : g_head
            assign shift_in = sample;
        end else begin : g_body
            assign shift_in = cell_q[i-1];
        end
        bcg_sample_cell u_cell (
            .aclk       (aclk),
            .shift_en   (take),
            .fill       (!primed_reg),
            .fill_value (sample),
            .shift_in   (shift_in),
            .sample_q   (cell_q[i])
        );
    end

    always_comb begin
        primed_next    = primed_reg | take;
        ctl_next.valid = take;
        ctl_next.first = !primed_reg;
        if (!primed_reg) begin
            sum_next = SUM_W'(WINDOW) * SUM_W'(sample);
        end else begin
            // drop the oldest sample, add the new one
            sum_next = sum_reg - SUM_W'(cell_q[WINDOW-1]) + SUM_W'(sample);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            ctl_reg    <= '0;
        end else if (en) begin
            primed_reg <= primed_next;
            ctl_reg    <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            sum_reg <= sum_next;
        end
    end

    assign ctl_q = ctl_reg;
    assign sum_q = sum_reg;

endmodule

[rtl/core/bcg_filter.sv]
// ----------------------------------------------------------------------------
// bcg_filter: first-order IIR on the window sum
// acc = acc - acc/2^IIR_SHIFT + sum; the first transaction seeds the
// accumulator so the first filtered value equals the sum.
// ----------------------------------------------------------------------------
module bcg_filter
    import bcg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  bcg_ctl_t          ctl_in,
    input  sum_t              sum,
    output logic              valid_q,
    output logic [FILT_W-1:0] filt_q
);

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic             valid_reg;

    always_comb begin
        if (ctl_in.first) begin
            acc_next = ACC_W'(sum) << IIR_SHIFT;
        end else begin
            acc_next = acc_reg - (acc_reg >> IIR_SHIFT) + ACC_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
            if (ctl_in.valid) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign valid_q = valid_reg;
    assign filt_q  = acc_reg[IIR_SHIFT +: FILT_W];

endmodule

[rtl/core/bcg_scale.sv]
// ----------------------------------------------------------------------------
// bcg_scale: millivolt scaling and charge curve
// One stage multiplies by the reciprocal of the mV scale; the next maps mV
// to percent and holds the result transaction for the output channel.
// ----------------------------------------------------------------------------
module bcg_scale
    import bcg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  logic [FILT_W-1:0] filt,
    output logic              valid_q,
    output logic [PCT_W-1:0]  pct_q,
    output logic [MV_W-1:0]   mv_q,
    output logic [FILT_W-1:0] filt_q
);

    localparam int PROD_W   = FILT_W + MV_MULT_W;
    localparam int P6_W     = SEG_W + DIV6_MULT_W;
    localparam int P29_W    = SEG_W + DIV29_MULT_W;

    logic [PROD_W-1:0]  prod;
    logic [MV_W-1:0]    mv_next;
    logic [MV_W-1:0]    mv_s1_reg;
    logic [FILT_W-1:0]  filt_s1_reg;
    logic               valid_s1_reg;

    logic [SEG_W-1:0]   seg_mid;
    logic [SEG_W-1:0]   seg_low;
    logic [P6_W-1:0]    prod6;
    logic [P29_W-1:0]   prod29;
    logic [PCT_W-1:0]   pct_next;

    logic               valid_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [MV_W-1:0]    mv_reg;
    logic [FILT_W-1:0]  filt_reg;

    always_comb begin
        prod    = PROD_W'(filt) * PROD_W'(MV_MULT);
        mv_next = prod[MV_SHIFT +: MV_W];
    end

    always_comb begin
        seg_mid = SEG_W'(mv_s1_reg - MV_W'(MV_MID));
        seg_low = SEG_W'(mv_s1_reg - MV_W'(MV_EMPTY));
        prod6   = P6_W'(seg_mid) * P6_W'(DIV6_MULT);
        prod29  = P29_W'(seg_low) * P29_W'(DIV29_MULT);
        if (mv_s1_reg >= MV_W'(MV_FULL)) begin
            pct_next = PCT_W'(PCT_FULL);
        end else if (mv_s1_reg >= MV_W'(MV_MID)) begin
            pct_next = PCT_W'(prod6 >> DIV6_SHIFT) + PCT_W'(PCT_MID);
        end else if (mv_s1_reg >= MV_W'(MV_EMPTY)) begin
            pct_next = PCT_W'(prod29 >> DIV29_SHIFT);
        end else begin
            pct_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_s1_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else if (en) begin
            valid_s1_reg <= valid_in;
            valid_reg    <= valid_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mv_s1_reg   <= mv_next;
            filt_s1_reg <= filt;
            pct_reg     <= pct_next;
            mv_reg      <= mv_s1_reg;
            filt_reg    <= filt_s1_reg;
        end
    end

    assign valid_q = valid_reg;
    assign pct_q   = pct_reg;
    assign mv_q    = mv_reg;
    assign filt_q  = filt_reg;

endmodule

[rtl/core/battery_charge_gauge.sv]
// ----------------------------------------------------------------------------
// battery_charge_gauge: battery fuel gauge from ADC samples
// Moving sum over a four-sample window, 1/64 IIR filter, mV scaling and a
// piecewise charge percent curve.
// ----------------------------------------------------------------------------
// Each accepted sample produces exactly one result transaction. One sample
// can be accepted every cycle; the pipeline is window sum, IIR accumulator,
// mV multiply and percent/output register, and the whole pipeline holds
// while a finished result waits on m_ready. The first sample after reset
// fills the window and seeds the filter, so its filtered_sum equals four
// times that sample.
module battery_charge_gauge
    import bcg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PCT_W-1:0]       m_charge_percent,
    output logic [MV_W-1:0]        m_battery_mv,
    output logic [FILT_W-1:0]      m_filtered_sum
);

    logic              en;
    logic              take;
    bcg_ctl_t          win_ctl;
    sum_t              win_sum;
    logic              filt_valid;
    logic [FILT_W-1:0] filt;

    // advance the pipeline unless a result is waiting to be taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign take    = s_valid && en;

    bcg_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .take    (take),
        .sample  (sample_t'(s_sample)),
        .ctl_q   (win_ctl),
        .sum_q   (win_sum)
    );

    bcg_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .ctl_in  (win_ctl),
        .sum     (win_sum),
        .valid_q (filt_valid),
        .filt_q  (filt)
    );

    bcg_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .valid_in (filt_valid),
        .filt     (filt),
        .valid_q  (m_valid),
        .pct_q    (m_charge_percent),
        .mv_q     (m_battery_mv),
        .filt_q   (m_filtered_sum)
    );

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for battery_charge_gauge
// Drives ADC samples with random gaps and output stalls, predicts the window
// sum, IIR filter, millivolt scaling and charge curve for every accepted
// sample, and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module tb_top
    import bcg_pkg::*;
();

    localparam int TARGET_ITEMS   = 600;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_GAP        = 9;
    localparam bit TYPED          = 1'b1;
    localparam bit PREDICTED      = 1'b0;

    typedef struct packed {
        logic [PCT_W-1:0]  pct;
        logic [MV_W-1:0]   mv;
        logic [FILT_W-1:0] filt;
    } reading_t;

    typedef struct packed {
        sample_t  smp;
        logic     typed;
        reading_t want;
    } stim_row_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sample_t           s_sample = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [PCT_W-1:0]  m_charge_percent;
    logic [MV_W-1:0]   m_battery_mv;
    logic [FILT_W-1:0] m_filtered_sum;

    // Gauge state as predicted
    sample_t     win_samples [WINDOW];
    int unsigned win_slot      = 0;
    bit          filter_seeded = 1'b0;
    int unsigned filter_acc    = 0;

    reading_t expected_readings [$];
    reading_t head_reading;
    int       error_count   = 0;
    int       quiet_cycles  = 0;
    bit       back_to_back  = 1'b0;
    bit       hold_output   = 1'b0;

    // The first two rows are fully determined: a full-scale first sample fills
    // the window and seeds the filter, and repeating it leaves the filter put.
    stim_row_t directed_rows [16] = '{
        '{12'hFFF, TYPED,     '{7'd100, 15'd20933, 14'd16380}},
        '{12'hFFF, TYPED,     '{7'd100, 15'd20933, 14'd16380}},
        '{12'h000, PREDICTED, '0},
        '{12'h000, PREDICTED, '0},
        '{12'h000, PREDICTED, '0},
        '{12'h000, PREDICTED, '0},
        '{12'hAAA, PREDICTED, '0},
        '{12'h555, PREDICTED, '0},
        '{12'hFFF, PREDICTED, '0},
        '{12'h800, PREDICTED, '0},
        '{12'h7FF, PREDICTED, '0},
        '{12'h001, PREDICTED, '0},
        '{12'hFFE, PREDICTED, '0},
        '{12'h24B, PREDICTED, '0},
        '{12'h30F, PREDICTED, '0},
        '{12'h000, PREDICTED, '0}
    };

    battery_charge_gauge i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_charge_percent (m_charge_percent),
        .m_battery_mv     (m_battery_mv),
        .m_filtered_sum   (m_filtered_sum)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic reading_t next_reading(input sample_t smp);
        int unsigned window_sum;
        int unsigned filt;
        int unsigned mv;
        reading_t    r;
        win_samples[win_slot] = smp;
        win_slot = (win_slot + 1) % WINDOW;
        if (!filter_seeded) begin
            for (int i = 0; i < WINDOW; i++) win_samples[i] = smp;
        end
        window_sum = 0;
        for (int i = 0; i < WINDOW; i++) window_sum += win_samples[i];
        if (!filter_seeded) begin
            filter_acc    = window_sum << IIR_SHIFT;
            filter_seeded = 1'b1;
        end
        filter_acc = filter_acc - (filter_acc >> IIR_SHIFT) + window_sum;
        filt = filter_acc >> IIR_SHIFT;
        mv   = filt * MV_NUM / MV_DEN;
        if (mv >= MV_FULL)
            r.pct = PCT_W'(PCT_FULL);
        else if (mv >= MV_MID)
            r.pct = PCT_W'((mv - MV_MID) / SLOPE_MID + PCT_MID);
        else if (mv >= MV_EMPTY)
            r.pct = PCT_W'((mv - MV_EMPTY) / SLOPE_LOW);
        else
            r.pct = '0;
        r.mv   = MV_W'(mv);
        r.filt = FILT_W'(filt);
        return r;
    endfunction

    function automatic int draw_gap();
        return back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one sample, hold it until the handshake, then queue its reading.
    task automatic drive_sample(input sample_t smp, input logic typed, input reading_t want);
        int       gap;
        reading_t predicted;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        predicted = next_reading(smp);
        expected_readings.push_back(typed ? want : predicted);
    endtask

    // Stop offering until every queued reading has been delivered.
    task automatic drain_readings();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_readings.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            error_count++;
        end
    endtask

    // Stimulus
    initial begin
        int      items_sent;
        int      run_kind;
        int      run_len;
        int      level;
        sample_t smp;
        bit      hold_issued;
        hold_issued = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int row = 0; row < $size(directed_rows); row++) begin
            drive_sample(directed_rows[row].smp, directed_rows[row].typed,
                         directed_rows[row].want);
        end
        items_sent = $size(directed_rows);
        drain_readings();

        // Mostly steady levels with small ripple so the filter settles across
        // the whole charge curve; the rest is wideband noise and rail swings.
        while (items_sent < TARGET_ITEMS) begin
            run_kind     = $urandom_range(0, 9);
            back_to_back = ($urandom_range(0, 3) == 0);
            level        = $urandom_range(540, 830);
            run_len      = (run_kind < 7) ? $urandom_range(20, 70) : $urandom_range(4, 15);
            if (!hold_issued && items_sent >= TARGET_ITEMS / 2) begin
                hold_output = 1'b1;
                hold_issued = 1'b1;
            end
            for (int k = 0; k < run_len; k++) begin
                if (run_kind < 7)
                    smp = sample_t'(level + $urandom_range(0, 8) - 4);
                else if (run_kind == 7)
                    smp = sample_t'($urandom_range(0, 4095));
                else
                    smp = k[0] ? sample_t'(12'hFFF) : sample_t'(12'h000);
                drive_sample(smp, PREDICTED, '0);
            end
            items_sent += run_len;
            if ($urandom_range(0, 15) == 0) drain_readings();
        end

        drain_readings();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side backpressure
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_output) begin
                stall       = LONG_HOLD;
                hold_output = 1'b0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                $error("result transaction with no reading expected: pct %0d mv %0d filt %0d",
                       m_charge_percent, m_battery_mv, m_filtered_sum);
                error_count++;
            end else begin
                head_reading = expected_readings.pop_front();
                check_field("charge_percent", head_reading.pct, m_charge_percent);
                check_field("battery_mv", head_reading.mv, m_battery_mv);
                check_field("filtered_sum", head_reading.filt, m_filtered_sum);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
